>>> rtl/bitplane_rectangle_clear_defines.svh
// Assertion macros shared by the bitplane rectangle clear checkers
`ifndef BITPLANE_RECTANGLE_CLEAR_DEFINES_SVH
`define BITPLANE_RECTANGLE_CLEAR_DEFINES_SVH

// check cons in the same cycle as ante
`define BRC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// check cons in the cycle after ante
`define BRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

>>> rtl/brc_pkg.sv
// Package: constants, codes and types of the bitplane rectangle clear block
package brc_pkg;

   localparam int DEF_LONGS_PER_LINE = 40;
   localparam int DEF_SCREEN_LINES   = 256;

   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   localparam logic STATUS_DONE   = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_LINE,
      ST_RD,
      ST_WR,
      ST_RDWAIT,
      ST_RESP
   } brc_state_type;

   typedef struct packed {
      logic       first;
      logic       last;
      logic [3:0] x_lo;
      logic [3:0] end_lo;
   } brc_edge_type;

endpackage

>>> rtl/brc_if.sv
// Interfaces: request and response channels with valid/ready handshake
interface brc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [8:0]  rect_x;
   logic [7:0]  rect_y;
   logic [8:0]  rect_width;
   logic [7:0]  rect_height;
   logic [13:0] long_index;
   logic [31:0] write_data;

   modport source (
      output valid, req_type, rect_x, rect_y, rect_width, rect_height, long_index,
         write_data,
      input  ready
   );
   modport sink (
      input  valid, req_type, rect_x, rect_y, rect_width, rect_height, long_index,
         write_data,
      output ready
   );
endinterface

interface brc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        status;

   modport source (
      output valid, read_data, status,
      input  ready
   );
   modport sink (
      input  valid, read_data, status,
      output ready
   );
endinterface

>>> rtl/brc_ram.sv
// Generic single-write, single-read RAM with registered read data
module brc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/brc_mask.sv
// Keep-mask unit: edge masks for the column word under the sequencer
module brc_mask (
   input  brc_pkg::brc_edge_type col_edge,
   output logic [31:0]           keep
);

   logic [3:0]  right_cnt;
   logic [15:0] half_left;
   logic [15:0] half_right;
   logic [16:0] right_ones;

   always_comb begin
      right_cnt  = 4'd0 - col_edge.end_lo;
      half_left  = ~(16'hffff >> col_edge.x_lo);
      right_ones = (17'd1 << right_cnt) - 17'd1;
      half_right = right_ones[15:0];
      keep       = '0;
      if (col_edge.first) begin
         keep = keep | {half_left, half_left};
      end
      if (col_edge.last) begin
         keep = keep | {half_right, half_right};
      end
   end

endmodule

>>> rtl/brc_seq.sv
// Sequencer: request decode, clearing pass, read-modify-write walk, response register
module brc_seq #(
   parameter int LONGS_PER_LINE = brc_pkg::DEF_LONGS_PER_LINE,
   parameter int SCREEN_LINES   = brc_pkg::DEF_SCREEN_LINES,
   localparam int MEM_LONGS     = LONGS_PER_LINE * SCREEN_LINES,
   localparam int AW            = $clog2(MEM_LONGS)
) (
   input  logic                  clock,
   input  logic                  reset,
   brc_req_if.sink               req_chan,
   brc_rsp_if.source             rsp_chan,
   output logic                  mem_we,
   output logic [AW-1:0]         mem_addr,
   output logic [31:0]           mem_wdata,
   input  logic [31:0]           mem_rd_data,
   output brc_pkg::brc_edge_type col_edge,
   input  logic [31:0]           keep
);

   localparam int SCREEN_PIXELS = (LONGS_PER_LINE / 2) * 16;
   localparam int COLS          = LONGS_PER_LINE / 2;
   localparam int COL_W         = (COLS > 1) ? $clog2(COLS) : 1;

   brc_pkg::brc_state_type state_ff, state_in;

   logic [1:0]       kind_ff, kind_in;
   logic [8:0]       x_ff, x_in;
   logic [7:0]       y_ff, y_in;
   logic [8:0]       w_ff, w_in;
   logic [7:0]       h_ff, h_in;
   logic [13:0]      idx_ff, idx_in;
   logic [31:0]      wdata_ff, wdata_in;
   logic [COL_W-1:0] first_ff, first_in;
   logic [COL_W-1:0] last_ff, last_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             half_ff, half_in;
   logic [7:0]       lines_ff, lines_in;
   logic [AW-1:0]    row_base_ff, row_base_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic [31:0]      rsp_data_ff, rsp_data_in;
   logic             rsp_status_ff, rsp_status_in;

   logic             req_acc;
   logic             rsp_acc;
   logic [9:0]       x_end;
   logic [9:0]       x_end_m1;
   logic [8:0]       y_end;
   logic             clear_ok;
   logic             idx_ok;
   logic             row_done;
   logic [31:0]      row_prod;
   logic [AW-1:0]    add_a;
   logic [AW-1:0]    add_b;
   logic [AW-1:0]    add_sum;

   assign req_acc  = req_chan.valid && req_chan.ready;
   assign rsp_acc  = rsp_chan.valid && rsp_chan.ready;
   assign x_end    = {1'b0, x_ff} + {1'b0, w_ff};
   assign x_end_m1 = x_end - 10'd1;
   assign y_end    = {1'b0, y_ff} + {1'b0, h_ff};
   assign clear_ok = (w_ff != 9'd0) && (32'(x_end) <= 32'(SCREEN_PIXELS))
                     && (32'(y_end) <= 32'(SCREEN_LINES));
   assign idx_ok   = 32'(idx_ff) < 32'(MEM_LONGS);
   assign row_done = half_ff && (col_ff == last_ff);
   assign row_prod = 32'(y_ff) * 32'(LONGS_PER_LINE);

   assign col_edge.first  = (col_ff == first_ff);
   assign col_edge.last   = (col_ff == last_ff);
   assign col_edge.x_lo   = x_ff[3:0];
   assign col_edge.end_lo = x_end[3:0];

   // shared address adder
   always_comb begin
      add_a = addr_ff;
      add_b = AW'(1);
      case (state_ff)
         brc_pkg::ST_LINE: begin
            add_a = row_base_ff;
            add_b = AW'({first_ff, 1'b0});
         end
         brc_pkg::ST_WR: begin
            if (row_done) begin
               add_a = row_base_ff;
               add_b = AW'(LONGS_PER_LINE);
            end
         end
         default: begin
            add_a = addr_ff;
            add_b = AW'(1);
         end
      endcase
   end

   assign add_sum = add_a + add_b;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         brc_pkg::ST_INIT: begin
            if (addr_ff == AW'(MEM_LONGS - 1)) begin
               state_in = brc_pkg::ST_IDLE;
            end
         end
         brc_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = brc_pkg::ST_DECODE;
            end
         end
         brc_pkg::ST_DECODE: begin
            if (kind_ff == brc_pkg::REQ_CLEAR && clear_ok && h_ff != 8'd0) begin
               state_in = brc_pkg::ST_LINE;
            end else if (kind_ff == brc_pkg::REQ_READ && idx_ok) begin
               state_in = brc_pkg::ST_RDWAIT;
            end else begin
               state_in = brc_pkg::ST_RESP;
            end
         end
         brc_pkg::ST_LINE:   state_in = brc_pkg::ST_RD;
         brc_pkg::ST_RD:     state_in = brc_pkg::ST_WR;
         brc_pkg::ST_WR: begin
            if (!row_done) begin
               state_in = brc_pkg::ST_RD;
            end else if (lines_ff == 8'd1) begin
               state_in = brc_pkg::ST_RESP;
            end else begin
               state_in = brc_pkg::ST_LINE;
            end
         end
         brc_pkg::ST_RDWAIT: state_in = brc_pkg::ST_RESP;
         brc_pkg::ST_RESP: begin
            if (rsp_acc) begin
               state_in = brc_pkg::ST_IDLE;
            end
         end
         default: state_in = brc_pkg::ST_INIT;
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      mem_we         = 1'b0;
      mem_addr       = addr_ff;
      mem_wdata      = '0;
      unique case (state_ff)
         brc_pkg::ST_INIT: begin
            mem_we = 1'b1;
         end
         brc_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         brc_pkg::ST_DECODE: begin
            mem_addr  = AW'(idx_ff);
            mem_we    = (kind_ff == brc_pkg::REQ_WRITE) && idx_ok;
            mem_wdata = wdata_ff;
         end
         brc_pkg::ST_WR: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rd_data & keep;
         end
         brc_pkg::ST_RESP: begin
            rsp_chan.valid = 1'b1;
         end
         default: begin
            mem_addr = addr_ff;
         end
      endcase
   end

   always_comb begin
      kind_in       = kind_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      idx_in        = idx_ff;
      wdata_in      = wdata_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      col_in        = col_ff;
      half_in       = half_ff;
      lines_in      = lines_ff;
      row_base_in   = row_base_ff;
      addr_in       = addr_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         brc_pkg::ST_INIT: begin
            addr_in = add_sum;
         end
         brc_pkg::ST_IDLE: begin
            if (req_acc) begin
               kind_in  = req_chan.req_type;
               x_in     = req_chan.rect_x;
               y_in     = req_chan.rect_y;
               w_in     = req_chan.rect_width;
               h_in     = req_chan.rect_height;
               idx_in   = req_chan.long_index;
               wdata_in = req_chan.write_data;
            end
         end
         brc_pkg::ST_DECODE: begin
            first_in      = COL_W'(x_ff[8:4]);
            last_in       = COL_W'(x_end_m1[9:4]);
            col_in        = COL_W'(x_ff[8:4]);
            half_in       = 1'b0;
            lines_in      = h_ff;
            row_base_in   = AW'(row_prod);
            rsp_data_in   = '0;
            rsp_status_in = brc_pkg::STATUS_REJECT;
            unique case (kind_ff) inside
               brc_pkg::REQ_CLEAR: begin
                  if (clear_ok) begin
                     rsp_status_in = brc_pkg::STATUS_DONE;
                  end
               end
               brc_pkg::REQ_WRITE, brc_pkg::REQ_READ: begin
                  if (idx_ok) begin
                     rsp_status_in = brc_pkg::STATUS_DONE;
                  end
               end
               default: rsp_status_in = brc_pkg::STATUS_REJECT;
            endcase
         end
         brc_pkg::ST_LINE: begin
            addr_in = add_sum;
         end
         brc_pkg::ST_WR: begin
            if (row_done) begin
               lines_in    = lines_ff - 8'd1;
               row_base_in = add_sum;
               col_in      = first_ff;
               half_in     = 1'b0;
            end else begin
               addr_in = add_sum;
               half_in = ~half_ff;
               if (half_ff) begin
                  col_in = col_ff + COL_W'(1);
               end
            end
         end
         brc_pkg::ST_RDWAIT: begin
            rsp_data_in = mem_rd_data;
         end
         default: begin
            addr_in = addr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brc_pkg::ST_INIT;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      idx_ff        <= idx_in;
      wdata_ff      <= wdata_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      col_ff        <= col_in;
      half_ff       <= half_in;
      lines_ff      <= lines_in;
      row_base_ff   <= row_base_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.read_data = rsp_data_ff;
   assign rsp_chan.status    = rsp_status_ff;

endmodule

>>> rtl/bitplane_rectangle_clear.sv
// Top level: masked rectangle clear over an interleaved four-plane frame buffer
//
// req_chan takes one transaction at a time: clear a rectangle, write one long
// or read one long. rsp_chan returns exactly one transaction per request with
// read_data (zero except for a good read) and status (1 for bad bounds,
// bad address or unused request type).
// A write or a rejected request goes from ST_DECODE straight to ST_RESP, a read
// through ST_RDWAIT. A clear takes ST_LINE per line, then ST_RD and ST_WR per
// long of its column words: each long takes a read and a write through the
// single frame buffer port; the shared address adder steps one long per write.
// req_chan.ready is high only while the block is idle; it stays low from the
// accepted request until its response transaction is taken.
// The response is held in an output register until rsp_chan.ready; a stalled
// receiver holds the block in that state.
// After reset the block zeroes the frame buffer, one long a cycle, all
// LONGS_PER_LINE * SCREEN_LINES longs (10240 by default), and accepts no
// request until that pass ends.
module bitplane_rectangle_clear #(
   parameter int LONGS_PER_LINE = brc_pkg::DEF_LONGS_PER_LINE,
   parameter int SCREEN_LINES   = brc_pkg::DEF_SCREEN_LINES
) (
   input  logic      clock,
   input  logic      reset,
   brc_req_if.sink   req_chan,
   brc_rsp_if.source rsp_chan
);

   localparam int MEM_LONGS = LONGS_PER_LINE * SCREEN_LINES;
   localparam int AW        = $clog2(MEM_LONGS);

   logic                  mem_we;
   logic [AW-1:0]         mem_addr;
   logic [31:0]           mem_wdata;
   logic [31:0]           mem_rd_data;
   brc_pkg::brc_edge_type col_edge;
   logic [31:0]           keep;

   brc_seq #(
      .LONGS_PER_LINE (LONGS_PER_LINE),
      .SCREEN_LINES   (SCREEN_LINES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .mem_we      (mem_we),
      .mem_addr    (mem_addr),
      .mem_wdata   (mem_wdata),
      .mem_rd_data (mem_rd_data),
      .col_edge    (col_edge),
      .keep        (keep)
   );

   brc_mask u_mask (
      .col_edge (col_edge),
      .keep     (keep)
   );

   brc_ram #(
      .WIDTH (32),
      .DEPTH (MEM_LONGS)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_addr),
      .wr_data (mem_wdata),
      .rd_addr (mem_addr),
      .rd_data (mem_rd_data)
   );

endmodule

>>> rtl/brc_checker.sv
// Checker: port-level assertions for the bitplane rectangle clear, with bind
`include "bitplane_rectangle_clear_defines.svh"

module brc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_read_data,
   input logic        rsp_status
);

   logic pending_ff, pending_in;

   assign pending_in = (pending_ff || (req_valid && req_ready)) && !(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `BRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data) && $stable(rsp_status))
   `BRC_ASSERT_NOW(a_rsp_has_req, clock, reset, rsp_valid, pending_ff)
   `BRC_ASSERT_NOW(a_one_at_a_time, clock, reset, req_ready, !rsp_valid)
   `BRC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `BRC_ASSERT_NOW(a_reject_zero, clock, reset, rsp_valid && rsp_status, rsp_read_data == 32'd0)

endmodule

bind bitplane_rectangle_clear brc_checker u_brc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_read_data (rsp_chan.read_data),
   .rsp_status    (rsp_chan.status)
);

>>> tb/bitplane_rectangle_clear_test.sv
// Testbench: random and directed clear, write and read requests against a frame shadow
module bitplane_rectangle_clear_test;

   localparam int LINE_LONGS   = brc_pkg::DEF_LONGS_PER_LINE;
   localparam int FRAME_LINES  = brc_pkg::DEF_SCREEN_LINES;
   localparam int FRAME_LONGS  = LINE_LONGS * FRAME_LINES;
   localparam int SCREEN_WIDTH = (LINE_LONGS / 2) * 16;
   localparam int COLUMNS      = LINE_LONGS / 2;
   localparam int RANDOM_ITEMS = 1900;
   localparam int LONG_HOLD    = 600;
   localparam longint RUN_LIMIT = 64'd40_000_000;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  kind;
      logic [8:0]  x;
      logic [7:0]  y;
      logic [8:0]  w;
      logic [7:0]  h;
      logic [13:0] index;
      logic [31:0] data;
   } frame_request_type;

   typedef struct {
      logic [31:0] read_data;
      logic        status;
   } frame_response_type;

   typedef enum {RX_OPEN, RX_COIN, RX_RHYTHM, RX_SPARSE} stall_pattern_type;

   class frame_scoreboard;
      logic [31:0]        shadow [FRAME_LONGS];
      frame_response_type awaited [$];
      int                 errors;

      function new();
         foreach (shadow[i]) shadow[i] = '0;
         errors = 0;
      endfunction

      task report(string msg);
         if (errors < 40) $display("mismatch: %s", msg);
         errors++;
      endtask

      function logic clear_shadow(frame_request_type r);
         int unsigned x, y, w, h, k, first, last, row, col, addr;
         logic [15:0] lhalf, rhalf;
         logic [31:0] keep;
         x = 32'(r.x);
         y = 32'(r.y);
         w = 32'(r.w);
         h = 32'(r.h);
         if (w == 0 || x + w > SCREEN_WIDTH || y + h > FRAME_LINES) begin
            return brc_pkg::STATUS_REJECT;
         end
         if (h == 0) return brc_pkg::STATUS_DONE;
         k = x % 16;
         lhalf = (k == 0) ? 16'h0000 : 16'hffff << (16 - k);
         k = (16 - (x + w) % 16) % 16;
         rhalf = (16'h0001 << k) - 16'h0001;
         first = x / 16;
         last = (x + w - 1) / 16;
         for (col = first; col <= last; col++) begin
            if (first == last) keep = {lhalf | rhalf, lhalf | rhalf};
            else if (col == first) keep = {lhalf, lhalf};
            else if (col == last) keep = {rhalf, rhalf};
            else keep = '0;
            for (row = y; row < y + h; row++) begin
               addr = row * LINE_LONGS + col * 2;
               shadow[addr] &= keep;
               shadow[addr + 1] &= keep;
            end
         end
         return brc_pkg::STATUS_DONE;
      endfunction

      function void apply_request(frame_request_type r);
         frame_response_type resp;
         resp.read_data = '0;
         resp.status = brc_pkg::STATUS_REJECT;
         case (r.kind)
            brc_pkg::REQ_CLEAR: begin
               resp.status = clear_shadow(r);
            end
            brc_pkg::REQ_WRITE: begin
               if (r.index < FRAME_LONGS) begin
                  shadow[r.index] = r.data;
                  resp.status = brc_pkg::STATUS_DONE;
               end
            end
            brc_pkg::REQ_READ: begin
               if (r.index < FRAME_LONGS) begin
                  resp.read_data = shadow[r.index];
                  resp.status = brc_pkg::STATUS_DONE;
               end
            end
            default: ;
         endcase
         awaited.push_back(resp);
      endfunction

      task compare_response(logic [31:0] read_data, logic status);
         frame_response_type want;
         if (awaited.size() == 0) begin
            report($sformatf("unrequested transaction read_data %h status %b",
                             read_data, status));
            return;
         end
         want = awaited.pop_front();
         if (read_data !== want.read_data)
            report($sformatf("read_data %h, wanted %h", read_data, want.read_data));
         if (status !== want.status)
            report($sformatf("status %b, wanted %b", status, want.status));
      endtask
   endclass

   logic clock;
   logic reset;
   brc_req_if req_chan();
   brc_rsp_if rsp_chan();
   frame_scoreboard sb;

   int items_sent;
   int burst_left;
   int gap_limit;

   bitplane_rectangle_clear dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   function automatic frame_request_type random_req();
      frame_request_type r;
      r.kind = 2'($urandom_range(0, 3));
      r.x = 9'($urandom_range(0, 511));
      r.y = 8'($urandom_range(0, 255));
      r.w = 9'($urandom_range(0, 511));
      r.h = 8'($urandom_range(0, 255));
      r.index = 14'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                                : $urandom_range(0, FRAME_LONGS - 1));
      r.data = $urandom;
      return r;
   endfunction

   function automatic frame_request_type clear_req(int x, int y, int w, int h);
      frame_request_type r;
      r = random_req();
      r.kind = brc_pkg::REQ_CLEAR;
      r.x = 9'(x);
      r.y = 8'(y);
      r.w = 9'(w);
      r.h = 8'(h);
      return r;
   endfunction

   function automatic frame_request_type write_req(int index, logic [31:0] data);
      frame_request_type r;
      r = random_req();
      r.kind = brc_pkg::REQ_WRITE;
      r.index = 14'(index);
      r.data = data;
      return r;
   endfunction

   function automatic frame_request_type read_req(int index);
      frame_request_type r;
      r = random_req();
      r.kind = brc_pkg::REQ_READ;
      r.index = 14'(index);
      return r;
   endfunction

   task automatic offer(frame_request_type r);
      int gap;
      if (burst_left == 0) begin
         gap = (gap_limit == 0) ? 0 : $urandom_range(0, gap_limit);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_chan.valid <= 1'b1;
      req_chan.req_type <= r.kind;
      req_chan.rect_x <= r.x;
      req_chan.rect_y <= r.y;
      req_chan.rect_width <= r.w;
      req_chan.rect_height <= r.h;
      req_chan.long_index <= r.index;
      req_chan.write_data <= r.data;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.apply_request(r);
      items_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic clear_sequence(bit wide);
      int w, h, x, y, first, last, n, row, col, addr;
      int touched [$];
      if (wide) begin
         w = $urandom_range(1, SCREEN_WIDTH);
         h = $urandom_range(1, FRAME_LINES);
      end else begin
         w = $urandom_range(1, 48);
         h = $urandom_range(0, 12);
      end
      x = $urandom_range(0, SCREEN_WIDTH - w);
      y = $urandom_range(0, FRAME_LINES - h);
      first = x / 16;
      last = (x + w - 1) / 16;
      n = $urandom_range(1, 4);
      repeat (n) begin
         row = $urandom_range((y > 0) ? y - 1 : 0,
                              (y + h < FRAME_LINES) ? y + h : FRAME_LINES - 1);
         col = $urandom_range((first > 0) ? first - 1 : 0,
                              (last + 1 < COLUMNS) ? last + 1 : last);
         addr = row * LINE_LONGS + col * 2 + $urandom_range(0, 1);
         touched.push_back(addr);
         offer(write_req(addr, ($urandom_range(0, 3) == 0) ? 32'hffff_ffff : $urandom));
      end
      offer(clear_req(x, y, w, h));
      foreach (touched[i]) offer(read_req(touched[i]));
   endtask

   initial begin : run_limit
      #(RUN_LIMIT);
      $display("simulation failed");
      $finish;
   end

   initial begin : request_side
      int base;
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.req_type = brc_pkg::REQ_CLEAR;
      req_chan.rect_x = '0;
      req_chan.rect_y = '0;
      req_chan.rect_width = '0;
      req_chan.rect_height = '0;
      req_chan.long_index = '0;
      req_chan.write_data = '0;
      items_sent = 0;
      burst_left = 0;
      gap_limit = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      offer(read_req(0));
      offer(write_req(0, 32'hffff_ffff));
      offer(write_req(FRAME_LONGS - 1, 32'ha5a5_5a5a));
      offer(read_req(FRAME_LONGS - 1));
      offer(write_req(FRAME_LONGS, 32'h1234_5678));
      offer(read_req(16383));
      begin
         frame_request_type r;
         r = random_req();
         r.kind = REQ_UNUSED;
         offer(r);
      end
      offer(write_req(5 * LINE_LONGS, 32'hffff_ffff));
      offer(write_req(5 * LINE_LONGS + 1, 32'hffff_ffff));
      offer(write_req(5 * LINE_LONGS + 4, 32'hffff_ffff));
      offer(clear_req(3, 5, 10, 1));
      offer(read_req(5 * LINE_LONGS + 1));
      offer(clear_req(12, 5, 30, 1));
      offer(read_req(5 * LINE_LONGS));
      offer(read_req(5 * LINE_LONGS + 4));
      offer(clear_req(7, 3, 0, 4));
      offer(clear_req(SCREEN_WIDTH - 1, 0, 2, 1));
      offer(clear_req(0, FRAME_LINES - 1, 16, 2));
      offer(clear_req(511, 255, 511, 255));
      offer(clear_req(5, 9, 3, 0));
      offer(clear_req(SCREEN_WIDTH - 1, FRAME_LINES - 1, 1, 1));
      offer(read_req(FRAME_LONGS - 1));
      offer(clear_req(0, 0, SCREEN_WIDTH, FRAME_LINES));
      offer(read_req(0));

      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 3))
               0: gap_limit = 0;
               1: gap_limit = 2;
               2: gap_limit = 8;
               default: gap_limit = 30;
            endcase
         end
         if ($urandom_range(0, 9) < 6) clear_sequence($urandom_range(0, 99) == 0);
         else offer(random_req());
      end
      req_chan.valid <= 1'b0;

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.awaited.size() != 0)
         sb.report($sformatf("%0d transactions never returned", sb.awaited.size()));
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : response_side
      int cyc;
      int taken;
      int hold;
      bit held_off;
      stall_pattern_type pattern;
      cyc = 0;
      taken = 0;
      hold = 0;
      held_off = 1'b0;
      pattern = RX_OPEN;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            sb.compare_response(rsp_chan.read_data, rsp_chan.status);
            taken++;
         end
         @(negedge clock);
         if (!held_off && taken >= 150) begin
            held_off = 1'b1;
            hold = LONG_HOLD;
         end
         if (hold > 0) begin
            hold--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (cyc % 64 == 0) pattern = stall_pattern_type'($urandom_range(0, 3));
            case (pattern)
               RX_OPEN: rsp_chan.ready <= 1'b1;
               RX_COIN: rsp_chan.ready <= 1'($urandom_range(0, 1));
               RX_RHYTHM: rsp_chan.ready <= (cyc % 5) >= 2;
               default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
         cyc++;
      end
   end
endmodule
